// ===== sv/ehcr_pkg.sv =====
`default_nettype none

package ehcr_pkg;

    localparam int FRAME_BYTES_DEF = 45;
    localparam int POS_W           = 6;
    localparam int MIN_FRAME       = 38;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [POS_W-1:0] POS_MAX      = 6'h3F;
    localparam logic [POS_W-1:0] TYPE_HI_AT   = 6'h0C;
    localparam logic [POS_W-1:0] TYPE_LO_AT   = 6'h0D;
    localparam logic [POS_W-1:0] ECHO_TYPE_AT = 6'h0F;
    localparam logic [POS_W-1:0] KEYED_AT     = 6'h18;
    localparam logic [POS_W-1:0] NUMBER_AT    = 6'h22;

    localparam logic [15:0] ETHERTYPE_RST = 16'h888E;
    localparam logic [7:0]  ECHO_CODE_RST = 8'hBF;

    localparam logic [CFG_IDX_W-1:0] REG_ETHERTYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_CODE = 1'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic take_byte;  // a received byte is accepted
        logic check;      // evaluate the captured header after a frame end
        logic bump;       // advance the echo number, restart the read counter
        logic sum;        // form number plus key for the keyed field
        logic issue;      // read the next template byte
    } ehcr_cmd_t;

    typedef struct packed {
        logic locked;
        logic credit;     // room in the output queue for one more read
        logic rd_last;    // read counter is at the final template byte
        logic out_empty;  // output queue and read pipeline are empty
    } ehcr_status_t;

    // Bit reversal followed by inversion; it is its own inverse.
    function automatic logic [7:0] scramble(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = ~b[7-i];
        end
        return r;
    endfunction

    // Byte o of a big-endian 32-bit field, encoded for the wire.
    function automatic logic [7:0] field_byte(input logic [31:0] v, input logic [1:0] o);
        logic [7:0] b;
        case (o)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return scramble(b);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ehcr_ram.sv =====
`default_nettype none

module ehcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 45
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ehcr_ctrl.sv =====
`default_nettype none

module ehcr_ctrl
    import ehcr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    input  wire ehcr_status_t st,
    output      ehcr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BUMP,
        ST_SUM,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_BYTE)
                    begin
                        cmd.take_byte = 1'b1;
                        if (s_tlast && !st.locked)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    else if (st.locked)
                    begin
                        state_next = ST_BUMP;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.issue = st.credit;
                if (st.credit && st.rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (st.out_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ehcr_datapath.sv =====
`default_nettype none

module ehcr_datapath
    import ehcr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 s_tlast,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [7:0]           m_tdata,
    output      logic                 m_tlast,
    input  wire ehcr_cmd_t            cmd,
    output      ehcr_status_t         st
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(FRAME_BYTES - 1);
    localparam logic [POS_W:0]   FRAME_LEN = (POS_W+1)'(FRAME_BYTES);
    localparam logic [POS_W-1:0] LEN_OK_AT = POS_W'(MIN_FRAME - 1);

    // Configuration
    logic [15:0] ethertype_reg;
    logic [7:0]  echo_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ethertype_reg <= ETHERTYPE_RST;
            echo_code_reg <= ECHO_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ETHERTYPE: ethertype_reg <= cfg_data;
                REG_ECHO_CODE: echo_code_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Receive side
    logic [POS_W-1:0] pos_reg;
    logic             len_ok_reg;
    logic             locked_reg;
    logic [7:0]       type_hi_reg, type_lo_reg, echo_type_reg;
    logic [7:0]       keyed_reg  [4];
    logic [7:0]       number_reg [4];
    logic [POS_W-1:0] keyed_off, number_off;
    logic             capture;

    assign capture    = cmd.take_byte && !locked_reg;
    assign keyed_off  = pos_reg - KEYED_AT;
    assign number_off = pos_reg - NUMBER_AT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_ok_reg <= 1'b0;
        end
        else if (cmd.take_byte)
        begin
            if (s_tlast)
            begin
                pos_reg    <= '0;
                len_ok_reg <= (pos_reg >= LEN_OK_AT);
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // Header bytes are kept beside the template so the check needs no memory reads.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            if (pos_reg == TYPE_HI_AT)
            begin
                type_hi_reg <= s_tdata;
            end
            if (pos_reg == TYPE_LO_AT)
            begin
                type_lo_reg <= s_tdata;
            end
            if (pos_reg == ECHO_TYPE_AT)
            begin
                echo_type_reg <= s_tdata;
            end
            if (keyed_off < POS_W'(4))
            begin
                keyed_reg[keyed_off[1:0]] <= s_tdata;
            end
            if (number_off < POS_W'(4))
            begin
                number_reg[number_off[1:0]] <= s_tdata;
            end
        end
    end

    // Template memory
    logic          ram_we;
    logic [AW-1:0] rd_cnt_reg;
    logic [7:0]    ram_rdata;

    assign ram_we = capture && ({1'b0, pos_reg} < FRAME_LEN);

    ehcr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    // Echo state
    logic [31:0] echo_number_reg, echo_key_reg, sum_reg;
    logic [31:0] number_dec, keyed_dec;
    logic        header_match;

    assign number_dec = {scramble(number_reg[0]), scramble(number_reg[1]),
                         scramble(number_reg[2]), scramble(number_reg[3])};
    assign keyed_dec  = {scramble(keyed_reg[0]), scramble(keyed_reg[1]),
                         scramble(keyed_reg[2]), scramble(keyed_reg[3])};
    assign header_match = len_ok_reg && ({type_hi_reg, type_lo_reg} == ethertype_reg)
                          && (echo_type_reg == echo_code_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg      <= 1'b0;
            echo_number_reg <= '0;
            echo_key_reg    <= '0;
        end
        else if (cmd.check && header_match)
        begin
            locked_reg      <= 1'b1;
            echo_number_reg <= number_dec;
            echo_key_reg    <= keyed_dec - number_dec;
        end
        else if (cmd.bump)
        begin
            echo_number_reg <= echo_number_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= echo_number_reg + echo_key_reg;
        end
    end

    // Transmit side: one read in flight plus a two-entry output queue.
    logic          inflight_reg;
    logic [AW-1:0] inflight_addr_reg;
    logic [7:0]    q_data_reg [2];
    logic          q_last_reg [2];
    logic          q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0]    q_cnt_reg;
    logic          pop;
    logic [POS_W-1:0] a_ext, a_keyed, a_number;
    logic [7:0]    tx_byte;

    assign pop      = m_tvalid && m_tready;
    assign a_ext    = POS_W'(inflight_addr_reg);
    assign a_keyed  = a_ext - KEYED_AT;
    assign a_number = a_ext - NUMBER_AT;

    // The two echo fields are replaced on the way out; the stored template keeps the rest.
    always_comb
    begin
        if (a_keyed < POS_W'(4))
        begin
            tx_byte = field_byte(sum_reg, a_keyed[1:0]);
        end
        else if (a_number < POS_W'(4))
        begin
            tx_byte = field_byte(echo_number_reg, a_number[1:0]);
        end
        else
        begin
            tx_byte = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg   <= '0;
            inflight_reg <= 1'b0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            inflight_reg <= cmd.issue;
            if (cmd.bump)
            begin
                rd_cnt_reg <= '0;
            end
            else if (cmd.issue && (rd_cnt_reg != LAST_ADDR))
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (inflight_reg)
            begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, inflight_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            inflight_addr_reg <= rd_cnt_reg;
        end
        if (inflight_reg)
        begin
            q_data_reg[q_wr_ptr_reg] <= tx_byte;
            q_last_reg[q_wr_ptr_reg] <= (inflight_addr_reg == LAST_ADDR);
        end
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = q_data_reg[q_rd_ptr_reg];
    assign m_tlast  = q_last_reg[q_rd_ptr_reg];

    assign st.locked    = locked_reg;
    assign st.credit    = ({1'b0, q_cnt_reg} + {2'b0, inflight_reg}) < (3'd2 + {2'b0, pop});
    assign st.rd_last   = (rd_cnt_reg == LAST_ADDR);
    assign st.out_empty = (q_cnt_reg == 2'd0) && !inflight_reg;

endmodule

`default_nettype wire

// ===== sv/eapol_heartbeat_capture_and_replay_unit.sv =====
`default_nettype none

// Captures the first FRAME_BYTES bytes of received frames until one carries the
// configured EtherType and echo type code and is at least 38 bytes long; it then
// decodes the echo number and key from the two scrambled 4-byte fields and locks
// until reset. Each heartbeat tick while locked bumps the echo number and sends the
// captured frame again with both fields re-encoded. The final byte of a frame that
// arrives while unlocked is followed by a header check before the next item is
// accepted. A tick while locked is followed by the bump of the echo number, the sum
// of number and key, an emit phase in which the single read port of the template
// memory delivers one byte a cycle while the output queue has room, and a drain
// phase in which the output queue empties and the controller sees it empty; no new
// item is accepted until the last byte has been taken. A tick while unlocked gives
// no output.
module eapol_heartbeat_capture_and_replay_unit
    import ehcr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte
    input  wire logic                 s_tuser,   // kind
    input  wire logic                 s_tlast,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [7:0]           m_tdata,   // tx_byte
    output      logic                 m_tlast
);

    ehcr_cmd_t    cmd;
    ehcr_status_t st;

    ehcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .st       (st),
        .cmd      (cmd)
    );

    ehcr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_eapol_heartbeat_capture_and_replay_unit.sv =====
`timescale 1ns / 100ps

module tb_eapol_heartbeat_capture_and_replay_unit;
    import ehcr_pkg::*;

    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [7:0] tdata;
        logic       tlast;
    } tx_beat_t;

    // Tracks the captured frame and the echo counter, and holds the heartbeat
    // bytes that are due on the output in order.
    class heartbeat_scoreboard;
        logic [15:0]      ethertype;
        logic [7:0]       echo_code;
        logic [POS_W-1:0] rx_index;
        logic [7:0]       frame_copy [FRAME_BYTES_DEF];
        bit               armed;
        logic [31:0]      seq_no;
        logic [31:0]      seq_key;
        tx_beat_t         tx_due [$];
        int               mismatches;
        int               bytes_checked;
        int               replays;

        function new();
            ethertype = ETHERTYPE_RST;
            echo_code = ECHO_CODE_RST;
            rx_index  = '0;
            armed     = 1'b0;
            seq_no    = '0;
            seq_key   = '0;
            foreach (frame_copy[i])
                frame_copy[i] = 8'h00;
            mismatches    = 0;
            bytes_checked = 0;
            replays       = 0;
        endfunction

        // Reverses the bit order and inverts; applying it twice gives the input back.
        static function logic [7:0] swizzle(logic [7:0] b);
            return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} ^ 8'hFF;
        endfunction

        function logic [31:0] read_field(int at);
            logic [31:0] v;
            v = '0;
            for (int i = 0; i < 4; i++)
                v = {v[23:0], swizzle(frame_copy[at + i])};
            return v;
        endfunction

        function void write_field(int at, logic [31:0] v);
            for (int i = 0; i < 4; i++)
                frame_copy[at + i] = swizzle(v[31 - 8 * i -: 8]);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_ETHERTYPE)
                ethertype = val[15:0];
            else
                echo_code = val[7:0];
        endfunction

        function int pending();
            return tx_due.size();
        endfunction

        function void take_rx_item(logic kind, logic [7:0] b, logic is_last);
            tx_beat_t beat;
            int       pos;
            if (kind == KIND_TICK)
            begin
                if (!armed)
                    return;
                seq_no = seq_no + 32'd1;
                write_field(KEYED_AT, seq_no + seq_key);
                write_field(NUMBER_AT, seq_no);
                replays++;
                for (int k = 0; k < FRAME_BYTES_DEF; k++)
                begin
                    beat.tdata = frame_copy[k];
                    beat.tlast = (k == FRAME_BYTES_DEF - 1);
                    tx_due.push_back(beat);
                end
                return;
            end
            pos = rx_index;
            if (!armed && pos < FRAME_BYTES_DEF)
                frame_copy[pos] = b;
            if (is_last)
            begin
                if (!armed && pos + 1 >= MIN_FRAME
                    && {frame_copy[TYPE_HI_AT], frame_copy[TYPE_LO_AT]} == ethertype
                    && frame_copy[ECHO_TYPE_AT] == echo_code)
                begin
                    seq_no  = read_field(NUMBER_AT);
                    seq_key = read_field(KEYED_AT) - seq_no;
                    armed   = 1'b1;
                end
                rx_index = '0;
            end
            else if (rx_index != POS_MAX)
            begin
                rx_index = rx_index + 1'b1;
            end
        endfunction

        function void check_tx_byte(logic [7:0] data, logic is_last);
            tx_beat_t want;
            bytes_checked++;
            if (tx_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output item: byte %02h last %0b", data, is_last);
                return;
            end
            want = tx_due.pop_front();
            if (data !== want.tdata || is_last !== want.tlast)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: output item %0d: expected byte %02h last %0b, got byte %02h last %0b",
                             bytes_checked, want.tdata, want.tlast, data, is_last);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    heartbeat_scoreboard sb;
    logic [7:0]  frame_buf [0:79];
    logic [15:0] cur_ethertype;
    logic [7:0]  cur_code;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_request;
    int          items_sent;
    int          idle_cycles;

    eapol_heartbeat_capture_and_replay_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one item, after a random gap, and returns once it has been taken.
    // The valid stays high so that a following item can go out back to back.
    task automatic send_item(logic kind, logic [7:0] b, logic is_last);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Waits on the clock first, so the monitor has noted the item that was just taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == REG_ETHERTYPE)
            cur_ethertype = val[15:0];
        else
            cur_code = val[7:0];
    endtask

    // Random frame content. With near_match the header carries the current
    // EtherType and echo code; without allow_match one of the three header
    // bytes is then spoiled so that the frame cannot lock the block.
    task automatic fill_frame(int len, bit near_match, bit allow_match);
        logic [7:0] flip;
        for (int i = 0; i < len; i++)
            frame_buf[i] = 8'($urandom);
        if (near_match)
        begin
            frame_buf[TYPE_HI_AT]   = cur_ethertype[15:8];
            frame_buf[TYPE_LO_AT]   = cur_ethertype[7:0];
            frame_buf[ECHO_TYPE_AT] = cur_code;
        end
        if (!allow_match && len >= MIN_FRAME
            && {frame_buf[TYPE_HI_AT], frame_buf[TYPE_LO_AT]} == cur_ethertype
            && frame_buf[ECHO_TYPE_AT] == cur_code)
        begin
            flip = 8'($urandom_range(255, 1));
            case ($urandom_range(2))
                0:       frame_buf[TYPE_HI_AT]   = frame_buf[TYPE_HI_AT] ^ flip;
                1:       frame_buf[TYPE_LO_AT]   = frame_buf[TYPE_LO_AT] ^ flip;
                default: frame_buf[ECHO_TYPE_AT] = frame_buf[ECHO_TYPE_AT] ^ flip;
            endcase
        end
    endtask

    task automatic play_frame(int len, int tick_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_item(KIND_TICK, 8'($urandom), 1'($urandom));
            send_item(KIND_BYTE, frame_buf[i], i == len - 1);
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_rx_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_tx_byte(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: nothing moved on either side for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] start_no;
        logic [31:0] start_sum;
        int          lock_items;
        int          seg_end;
        int          len;

        sb = new();
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_ETHERTYPE;
        cfg_data     <= '0;
        s_tvalid     <= 1'b0;
        s_tuser      <= KIND_BYTE;
        s_tdata      <= 8'h00;
        s_tlast      <= 1'b0;
        cur_ethertype = ETHERTYPE_RST;
        cur_code      = ECHO_CODE_RST;
        snd_idle_pct  = 25;
        rcv_idle_pct  = 63;
        hold_request  = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings. The first frame runs past the
        // saturation point and fills the whole template.
        fill_frame(66, 1'b1, 1'b0);
        play_frame(66, 0);
        send_item(KIND_TICK, 8'hFF, 1'b1);
        send_item(KIND_BYTE, 8'h00, 1'b1);
        send_item(KIND_BYTE, 8'hFF, 1'b1);
        // A matching header one byte too short must not lock.
        fill_frame(MIN_FRAME - 1, 1'b1, 1'b1);
        play_frame(MIN_FRAME - 1, 8);
        send_item(KIND_TICK, 8'h00, 1'b0);

        // Near misses under the extreme settings; ticks must stay silent.
        write_reg(REG_ETHERTYPE, 16'h0000);
        write_reg(REG_ECHO_CODE, 16'h0000);
        len = $urandom_range(48, 30);
        fill_frame(len, $urandom_range(1), 1'b0);
        play_frame(len, 5);
        send_item(KIND_TICK, 8'($urandom), 1'($urandom));
        write_reg(REG_ETHERTYPE, 16'hFFFF);
        write_reg(REG_ECHO_CODE, 16'h00FF);
        len = $urandom_range(48, 38);
        fill_frame(len, 1'b1, 1'b0);
        play_frame(len, 5);
        send_item(KIND_TICK, 8'($urandom), 1'($urandom));

        // Lock on a frame of minimum length, so the template tail keeps older
        // bytes. The echo number sits just below the wrap point.
        write_reg(REG_ETHERTYPE, ETHERTYPE_RST);
        write_reg(REG_ECHO_CODE, {8'h00, ECHO_CODE_RST});
        fill_frame(MIN_FRAME, 1'b1, 1'b1);
        start_no  = 32'hFFFF_FFFD;
        start_sum = $urandom;
        for (int i = 0; i < 4; i++)
        begin
            frame_buf[NUMBER_AT + i] = heartbeat_scoreboard::swizzle(start_no[31 - 8 * i -: 8]);
            frame_buf[KEYED_AT + i]  = heartbeat_scoreboard::swizzle(start_sum[31 - 8 * i -: 8]);
        end
        play_frame(MIN_FRAME, 10);

        // Locked: ticks mixed with frames that must leave the template alone.
        lock_items = items_sent;
        for (int seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    snd_idle_pct = 25;
                    rcv_idle_pct = 63;
                end
                1:
                begin
                    snd_idle_pct = 63;
                    rcv_idle_pct = 25;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            write_reg(REG_ETHERTYPE, 16'($urandom));
            write_reg(REG_ECHO_CODE, {8'h00, 8'($urandom)});
            if (seg == 2)
            begin
                // The output is held off while ticks keep coming, so the block
                // has to back up onto its input.
                hold_request = 1'b1;
                repeat (4) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
            end
            seg_end = lock_items + (ITEM_TARGET - lock_items) * (seg + 1) / 3;
            while (items_sent < seg_end)
            begin
                if ($urandom_range(99) < 45)
                begin
                    send_item(KIND_TICK, 8'($urandom), 1'($urandom));
                end
                else
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(70, 36) : $urandom_range(8, 1);
                    fill_frame(len, $urandom_range(1), 1'b1);
                    play_frame(len, 10);
                end
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        $display("Run covered %0d input items, %0d heartbeat replays and %0d output bytes,",
                 items_sent, sb.replays, sb.bytes_checked);
        $display("over three idling patterns and one long output hold; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ehcr_pkg.sv
sv/ehcr_ram.sv
sv/ehcr_ctrl.sv
sv/ehcr_datapath.sv
sv/eapol_heartbeat_capture_and_replay_unit.sv
tb/sv/tb_eapol_heartbeat_capture_and_replay_unit.sv
